/* hdl/deadline_slot_scheduler_macros.svh */
// Assertion macros for the checker file.
`ifndef DEADLINE_SLOT_SCHEDULER_MACROS_SVH
`define DEADLINE_SLOT_SCHEDULER_MACROS_SVH

// Implication in the same cycle, off while reset is held.
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, off while reset is held.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the next cycle, checked through reset too.
`define DSS_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dss_pkg.sv */
package dss_pkg;

  // Slot map is kept as rows of ROW_W slots.
  localparam int ROW_W     = 16;
  localparam int BIT_W     = 4;
  // Row number field wide enough for the largest slot count (1024 / 16).
  localparam int ROW_IDX_W = 6;

  localparam logic [21:0] PROFIT_MAX = 22'h3FFFFF;
  localparam logic [6:0]  COUNT_MAX  = 7'd127;

  typedef struct packed {
    logic [15:0]          job_id;
    logic [15:0]          profit;
    logic                 last;
    logic                 dl_ok;      // clamped deadline is nonzero
    logic [ROW_IDX_W-1:0] start_row;
    logic [BIT_W-1:0]     start_bit;
  } cmd_t;

  // Highest set bit of a row.
  function automatic logic [BIT_W-1:0] hi_bit(input logic [ROW_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Bits 0..b set.
  function automatic logic [ROW_W-1:0] upto_mask(input logic [BIT_W-1:0] b);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (BIT_W'(i) <= b);
    end
    return m;
  endfunction

endpackage

/* hdl/dss_front.sv */
module dss_front #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic [15:0]    in_job_id,
  input  logic [15:0]    in_deadline,
  input  logic [15:0]    in_profit,
  input  logic           in_end_of_set,
  output logic           cmd_avail,
  input  logic           cmd_pop,
  output dss_pkg::cmd_t  cmd
);
  import dss_pkg::*;

  localparam logic [15:0] SlotsW = 16'(SLOTS);

  logic [15:0] dl_clamp;
  logic [15:0] dl_m1;
  cmd_t        new_cmd;

  cmd_t        q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push_ok, pop_ok;

  // Clamp and split the deadline into row / bit of the latest candidate slot.
  always_comb begin
    dl_clamp          = (in_deadline > SlotsW) ? SlotsW : in_deadline;
    dl_m1             = dl_clamp - 16'd1;
    new_cmd.job_id    = in_job_id;
    new_cmd.profit    = in_profit;
    new_cmd.last      = in_end_of_set;
    new_cmd.dl_ok     = (dl_clamp != 16'd0);
    new_cmd.start_row = dl_m1[BIT_W +: ROW_IDX_W];
    new_cmd.start_bit = dl_m1[BIT_W-1:0];
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_avail = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_avail;

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= new_cmd;
  end

endmodule

/* hdl/dss_back.sv */
module dss_back #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_avail,
  output logic           cmd_pop,
  input  dss_pkg::cmd_t  cmd,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [15:0]    out_echo_id,
  output logic           out_placed,
  output logic [5:0]     out_slot_index,
  output logic [21:0]    out_profit_sum,
  output logic [6:0]     out_placed_count
);
  import dss_pkg::*;

  localparam int ROWS   = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_r;
  logic             rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_data;

  state_t            state_r, state_nxt;
  logic [ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic [ROW_W-1:0]  mask_r, mask_nxt;
  logic [15:0]       id_r, id_nxt;
  logic [15:0]       prof_r, prof_nxt;
  logic              last_r, last_nxt;
  logic              placed_r, placed_nxt;
  logic [5:0]        slot_r, slot_nxt;
  logic [21:0]       psum_r, psum_nxt;
  logic [6:0]        pcnt_r, pcnt_nxt;
  logic              ov_r, ov_nxt;
  logic [15:0]       o_id_r, o_id_nxt;
  logic              o_pl_r, o_pl_nxt;
  logic [5:0]        o_slot_r, o_slot_nxt;
  logic [21:0]       o_psum_r, o_psum_nxt;
  logic [6:0]        o_pcnt_r, o_pcnt_nxt;

  logic [ROW_W-1:0]           eff;
  logic [ROW_W-1:0]           free;
  logic [BIT_W-1:0]           hb;
  logic [22:0]                sum_w;
  logic [ROW_IDX_W+BIT_W-1:0] slot_w;

  assign out_empty        = !ov_r;
  assign out_echo_id      = o_id_r;
  assign out_placed       = o_pl_r;
  assign out_slot_index   = o_slot_r;
  assign out_profit_sum   = o_psum_r;
  assign out_placed_count = o_pcnt_r;

  always_comb begin
    // a row never written since the last clear reads as all free
    eff    = row_vld_r[row_r] ? rd_r : '0;
    free   = ~eff & mask_r;
    hb     = hi_bit(free);
    sum_w  = {1'b0, psum_r} + 23'(prof_r);
    slot_w = {ROW_IDX_W'(row_r), hb};

    state_nxt   = state_r;
    row_vld_nxt = row_vld_r;
    row_nxt     = row_r;
    mask_nxt    = mask_r;
    id_nxt      = id_r;
    prof_nxt    = prof_r;
    last_nxt    = last_r;
    placed_nxt  = placed_r;
    slot_nxt    = slot_r;
    psum_nxt    = psum_r;
    pcnt_nxt    = pcnt_r;
    ov_nxt      = ov_r && !out_pop;
    o_id_nxt    = o_id_r;
    o_pl_nxt    = o_pl_r;
    o_slot_nxt  = o_slot_r;
    o_psum_nxt  = o_psum_r;
    o_pcnt_nxt  = o_pcnt_r;
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = row_r;
    wr_en       = 1'b0;
    wr_data     = eff | (ROW_W'(1) << hb);

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_avail) begin
          cmd_pop    = 1'b1;
          id_nxt     = cmd.job_id;
          prof_nxt   = cmd.profit;
          last_nxt   = cmd.last;
          placed_nxt = 1'b0;
          slot_nxt   = '0;
          row_nxt    = cmd.start_row[ROW_AW-1:0];
          mask_nxt   = upto_mask(cmd.start_bit);
          if (cmd.dl_ok) begin
            rd_en     = 1'b1;
            rd_addr   = row_nxt;
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        if (|free) begin
          wr_en              = 1'b1;
          row_vld_nxt[row_r] = 1'b1;
          placed_nxt         = 1'b1;
          slot_nxt           = slot_w[5:0];
          psum_nxt           = (sum_w > 23'(PROFIT_MAX)) ? PROFIT_MAX : sum_w[21:0];
          pcnt_nxt           = (pcnt_r < COUNT_MAX) ? pcnt_r + 7'd1 : pcnt_r;
          state_nxt          = ST_DONE;
        end else if (row_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          // step down one row, whole row is a candidate now
          row_nxt  = row_r - ROW_AW'(1);
          mask_nxt = '1;
          rd_en    = 1'b1;
          rd_addr  = row_nxt;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_pop) begin
          ov_nxt     = 1'b1;
          o_id_nxt   = id_r;
          o_pl_nxt   = placed_r;
          o_slot_nxt = slot_r;
          o_psum_nxt = psum_r;
          o_pcnt_nxt = pcnt_r;
          if (last_r) begin
            row_vld_nxt = '0;
            psum_nxt    = '0;
            pcnt_nxt    = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
      psum_r    <= '0;
      pcnt_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      psum_r    <= psum_nxt;
      pcnt_r    <= pcnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    mask_r   <= mask_nxt;
    id_r     <= id_nxt;
    prof_r   <= prof_nxt;
    last_r   <= last_nxt;
    placed_r <= placed_nxt;
    slot_r   <= slot_nxt;
    o_id_r   <= o_id_nxt;
    o_pl_r   <= o_pl_nxt;
    o_slot_r <= o_slot_nxt;
    o_psum_r <= o_psum_nxt;
    o_pcnt_r <= o_pcnt_nxt;
  end

  // slot map rows, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[row_r] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

endmodule

/* hdl/deadline_slot_scheduler.sv */
// Greedy deadline scheduler: jobs arrive one word at a time (ideally in
// non-increasing profit order); each job takes the latest free unit slot at
// or before its deadline, which is clamped to SLOTS, and every job gives one
// result word with placed, the 0-based slot (low 6 bits, 0 if not placed)
// and the running profit (saturating at 22 bits) and count (saturating at
// 127) of the current set. A job with end_of_set high is handled normally,
// then the slot map and totals clear for the next job. The search engine
// scans 16-slot rows of the slot map from the deadline's row downward, up
// to ceil(SLOTS/16) rows, one registered row read per cycle from a row
// memory (one write, one read port); a zero deadline skips the search.
// The input queue holds two words, so jobs are taken while the engine
// searches and while a result waits to be popped. No clearing pass is needed
// after reset: each row has a valid flag that reset and end of set clear.
module deadline_slot_scheduler #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // job words
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_deadline,
  input  logic [15:0] in_profit,
  input  logic        in_end_of_set,
  // result words
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_echo_id,
  output logic        out_placed,
  output logic [5:0]  out_slot_index,
  output logic [21:0] out_profit_sum,
  output logic [6:0]  out_placed_count
);
  import dss_pkg::*;

  cmd_t cmd;
  logic cmd_avail;
  logic cmd_pop;

  // front: deadline clamp, row/bit split, two-word job queue
  dss_front #(.SLOTS(SLOTS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_job_id     (in_job_id),
    .in_deadline   (in_deadline),
    .in_profit     (in_profit),
    .in_end_of_set (in_end_of_set),
    .cmd_avail     (cmd_avail),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd)
  );

  // back: row-by-row downward search, slot map update, totals, result reg
  dss_back #(.SLOTS(SLOTS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_avail        (cmd_avail),
    .cmd_pop          (cmd_pop),
    .cmd              (cmd),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_echo_id      (out_echo_id),
    .out_placed       (out_placed),
    .out_slot_index   (out_slot_index),
    .out_profit_sum   (out_profit_sum),
    .out_placed_count (out_placed_count)
  );

endmodule

/* hdl/dss_checker.sv */
`include "deadline_slot_scheduler_macros.svh"

module dss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_echo_id,
  input logic        out_placed,
  input logic [5:0]  out_slot_index,
  input logic [21:0] out_profit_sum,
  input logic [6:0]  out_placed_count
);

  // a waiting result word holds until popped
  `DSS_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop,
    !out_empty && $stable(out_echo_id) && $stable(out_profit_sum),
    "result word changed before pop")

  // reset leaves both queues empty
  `DSS_ASSERT_NEXT_RST(a_rst_empty, !rst_n, out_empty && !in_full,
    "queues not empty after reset")

  // no placed job in the set means no profit and no placement
  `DSS_ASSERT_NOW(a_zero_count, !out_empty && out_placed_count == 7'd0,
    out_profit_sum == 22'd0 && !out_placed && out_slot_index == 6'd0,
    "totals disagree with count")

  // a placed job always leaves a nonzero count
  `DSS_ASSERT_NOW(a_placed_cnt, !out_empty && out_placed, out_placed_count != 7'd0,
    "placed job with zero count")

endmodule

bind deadline_slot_scheduler dss_checker u_dss_checker (.*);

/* dv/deadline_slot_scheduler_test.sv */
`timescale 1ns / 1ps

module deadline_slot_scheduler_test;

  import dss_pkg::*;

  localparam int NUM_SLOTS = 64;
  // Quiet stretches of a correct run come from the sender gap, the receiver
  // stall pattern and the engine search; the limit allows far more.
  localparam int QUIET_LIMIT = 1000;
  // Settle time once the last result is in: engine plus the two-word queue.
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_JOBS = 1500;

  // One predicted result word.
  typedef struct packed {
    logic [15:0] id;
    logic        placed;
    logic [5:0]  slot;
    logic [21:0] sum;
    logic [6:0]  count;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_job_id = '0;
  logic [15:0] in_deadline = '0;
  logic [15:0] in_profit = '0;
  logic        in_end_of_set = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_echo_id;
  logic        out_placed;
  logic [5:0]  out_slot_index;
  logic [21:0] out_profit_sum;
  logic [6:0]  out_placed_count;

  deadline_slot_scheduler #(
    .SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_job_id       (in_job_id),
    .in_deadline     (in_deadline),
    .in_profit       (in_profit),
    .in_end_of_set   (in_end_of_set),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_echo_id     (out_echo_id),
    .out_placed      (out_placed),
    .out_slot_index  (out_slot_index),
    .out_profit_sum  (out_profit_sum),
    .out_placed_count(out_placed_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: slot map and running totals of the current set
  // ---------------------------------------------------------------------------
  logic [NUM_SLOTS-1:0] slot_taken = '0;
  logic [21:0]          set_profit = '0;
  logic [6:0]           set_count = '0;

  placement_t placement_queue[$];

  int error_count = 0;
  int jobs_sent = 0;
  int sets_closed = 0;
  int results_checked = 0;
  int jobs_placed = 0;
  int jobs_rejected = 0;

  // Sender pacing: burst length left, and a flag that turns gaps off.
  int burst_left = 0;
  bit steady_feed = 1'b0;

  // Greedy placement of one job: latest free slot at or below the clamped
  // deadline. Totals saturate; end of set clears after the result is formed.
  function automatic placement_t place_job(input logic [15:0] id, input logic [15:0] dl,
                                           input logic [15:0] pr, input logic eos);
    placement_t r;
    int limit;
    logic [22:0] total;
    r = '0;
    r.id = id;
    limit = (dl > NUM_SLOTS) ? NUM_SLOTS : int'(dl);
    for (int d = limit; d > 0 && !r.placed; d--) begin
      if (!slot_taken[d-1]) begin
        slot_taken[d-1] = 1'b1;
        r.placed = 1'b1;
        r.slot = 6'(d - 1);
      end
    end
    if (r.placed) begin
      total = set_profit + pr;
      set_profit = (total > PROFIT_MAX) ? PROFIT_MAX : total[21:0];
      if (set_count < COUNT_MAX) set_count = set_count + 7'd1;
    end
    r.sum = set_profit;
    r.count = set_count;
    if (eos) begin
      slot_taken = '0;
      set_profit = '0;
      set_count = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one job word per call. Called at a rising edge; returns at the
  // edge that took the word with push still high, or after a gap with push low.
  // ---------------------------------------------------------------------------
  task automatic send_job(input logic [15:0] id, input logic [15:0] dl,
                          input logic [15:0] pr, input logic eos);
    int gap;
    in_push <= 1'b1;
    in_job_id <= id;
    in_deadline <= dl;
    in_profit <= pr;
    in_end_of_set <= eos;
    do @(posedge clk); while (in_full);
    placement_queue.push_back(place_job(id, dl, pr, eos));
    jobs_sent++;
    if (eos) sets_closed++;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (!steady_feed) gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop pattern changes each time the 6-bit phase counter wraps,
  // between always ready, a random 8-bit pattern, random 25% stalls and
  // sparse pops that back the input queue up into full.
  // ---------------------------------------------------------------------------
  logic [5:0] pop_phase = '0;
  logic [1:0] pop_mode = '0;
  logic [7:0] stall_pat = 8'hff;

  always @(posedge clk) begin
    pop_phase <= pop_phase + 6'd1;
    if (pop_phase == 6'd0) begin
      pop_mode <= 2'($urandom_range(0, 3));
      stall_pat <= 8'($urandom_range(1, 255));
    end
    case (pop_mode)
      2'd0: out_pop <= 1'b1;
      2'd1: out_pop <= stall_pat[pop_phase[2:0]];
      2'd2: out_pop <= ($urandom_range(0, 3) != 0);
      default: out_pop <= (pop_phase[2:0] == 3'd0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every popped word against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] id,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: job %04h %s expected %0d actual %0d", $time, id, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    placement_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (placement_queue.size() == 0) begin
        $display("%0t: result word for job %04h with no job pending, expected none actual %0d",
                 $time, out_echo_id, out_echo_id);
        error_count++;
      end else begin
        want = placement_queue.pop_front();
        check_field("echo_id", want.id, 32'(want.id), 32'(out_echo_id));
        check_field("placed", want.id, 32'(want.placed), 32'(out_placed));
        check_field("slot_index", want.id, 32'(want.slot), 32'(out_slot_index));
        check_field("profit_sum", want.id, 32'(want.sum), 32'(out_profit_sum));
        check_field("placed_count", want.id, 32'(want.count), 32'(out_placed_count));
        results_checked++;
        if (want.placed) jobs_placed++;
        else jobs_rejected++;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, placement_queue.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and each corner of the greedy search, starting from reset.
  task automatic test_directed();
    steady_feed = 1'b0;
    send_job(16'h0000, 16'd0, 16'hffff, 1'b0);     // zero deadline, never placed
    send_job(16'hffff, 16'd1, 16'hffff, 1'b0);     // takes slot 0
    send_job(16'h0001, 16'd1, 16'hffff, 1'b0);     // only candidate busy
    send_job(16'h0002, 16'd64, 16'hfff0, 1'b0);    // top slot
    send_job(16'h0003, 16'd65, 16'hff00, 1'b0);    // clamped, falls to 62
    send_job(16'h0004, 16'hffff, 16'hf000, 1'b0);  // max deadline, falls to 61
    send_job(16'h0005, 16'd16, 16'h8000, 1'b0);    // last slot of first row
    send_job(16'h0006, 16'd17, 16'h4000, 1'b0);    // first slot of second row
    send_job(16'h0007, 16'd17, 16'h2000, 1'b0);    // row crossing on the way down
    send_job(16'h0008, 16'd3, 16'h0000, 1'b0);     // zero profit still counts
    send_job(16'h0009, 16'd3, 16'h7fff, 1'b0);     // unsorted: higher profit later
    send_job(16'h000a, 16'd2, 16'h0001, 1'b0);     // slot 0..2 all taken now
    send_job(16'h5555, 16'haaaa, 16'h5555, 1'b1);  // placed and closes the set
    send_job(16'haaaa, 16'd1, 16'haaaa, 1'b0);     // map cleared: slot 0 again
    send_job(16'h000b, 16'd0, 16'h1234, 1'b1);     // rejected job closes the set
    send_job(16'h000c, 16'd5, 16'h0100, 1'b1);     // single-job sets back to back
    send_job(16'h000d, 16'd5, 16'h0100, 1'b1);
    send_job(16'h000e, 16'd64, 16'hffff, 1'b0);
    send_job(16'h000f, 16'd64, 16'hffff, 1'b1);
  endtask

  // Every slot filled at top profit, so the totals reach the highest values
  // a full map can give, then one more job finds the whole map busy.
  task automatic test_full_map();
    steady_feed = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_job(16'($urandom_range(0, 65535)), 16'(NUM_SLOTS), 16'hffff, 1'b0);
    end
    send_job(16'($urandom_range(0, 65535)), 16'hffff, 16'hffff, 1'b1);
    steady_feed = 1'b0;
  endtask

  // Random sets. Mostly well-formed: profits non-increasing, deadlines in
  // and just above the slot range, last job flagged. The rest are unsorted
  // sets, tiny sets and raw noise with random end flags.
  task automatic test_random_sets();
    int kind;
    int len;
    int step;
    int cur_profit;
    logic [15:0] dl;
    logic [15:0] pr;
    logic eos;
    while (jobs_sent < RANDOM_JOBS) begin
      kind = $urandom_range(0, 9);
      steady_feed = ($urandom_range(0, 3) == 0);
      len = (kind == 8) ? $urandom_range(1, 3) : $urandom_range(1, 90);
      cur_profit = $urandom_range(0, 65535);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 15))
          0: dl = 16'd0;
          1: dl = 16'($urandom_range(0, 65535));
          default: dl = 16'($urandom_range(1, NUM_SLOTS + 6));
        endcase
        if (kind <= 5 || kind == 8) begin
          step = $urandom_range(0, 3000);
          cur_profit = (step > cur_profit) ? 0 : cur_profit - step;
          pr = 16'(cur_profit);
        end else begin
          pr = 16'($urandom_range(0, 65535));
        end
        eos = (kind == 9) ? ($urandom_range(0, 15) == 0) : (j == len - 1);
        send_job(16'($urandom_range(0, 65535)), dl, pr, eos);
      end
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_map();
    test_random_sets();
    in_push <= 1'b0;

    // Drain, then give the engine time to show any stray word.
    while (placement_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d jobs in %0d closed sets: %0d results checked,", jobs_sent,
             sets_closed, results_checked);
    $display("  %0d placed, %0d rejected, %0d mismatches", jobs_placed, jobs_rejected,
             error_count);
    if (error_count == 0 && placement_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dss_pkg.sv
hdl/dss_front.sv
hdl/dss_back.sv
hdl/deadline_slot_scheduler.sv
hdl/dss_checker.sv
dv/deadline_slot_scheduler_test.sv
